// ===== src/hrrn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the two-level HRRN slot scheduler.
// No dependencies; every file but hrrn_div imports this package.
package hrrn_pkg;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic LEVEL_HIGH = 1'b0;
	localparam logic LEVEL_LOW  = 1'b1;

	localparam logic [15:0] THRESH_RESET = 16'd10;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [7:0]  burst;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ARRIVE,
		S_REL,
		S_CHK,
		S_RD,
		S_LOAD,
		S_DIVW,
		S_CMP,
		S_SWAP0,
		S_SWAP1,
		S_PROMO,
		S_DISP,
		S_REPORT
	} ctrl_state_t;

	typedef struct packed {
		logic latch;
		logic push;
		logic rel_chk;
		logic scan_init;
		logic scan_sel;
		logic div_start;
		logic cmp;
		logic swap0;
		logic swap1;
		logic promote;
		logic dispatch;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic holder_valid;
		logic h_empty;
		logic l_empty;
		logic sel;
		logic scan_last;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== src/hrrn_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle (16 by 8 bits).
// Depends on nothing else.
module hrrn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic [15:0] quotient,
	output logic        busy
);

	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [7:0]  dsr_q;
	logic [3:0]  step_q;
	logic        busy_q;
	logic [8:0]  trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'd15)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

// ===== src/hrrn_dp.sv =====
`timescale 1ns / 1ps
// Datapath: two circular queues in memories, ratio scan, holder and result register.
// Depends on hrrn_pkg and hrrn_div.
module hrrn_dp import hrrn_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        op,
	input  logic [7:0]  requester_id,
	input  logic        level,
	input  logic [7:0]  slots_wanted,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	output logic [15:0] slot_time,
	output logic [7:0]  running_id,
	output logic        busy_res,
	output logic        dropped,
	output logic        out_valid,
	input  logic        out_stall
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_P)
			s = s - DEPTH_P;
		return s[PTR_W-1:0];
	endfunction

	entry_t mem_h_q [QUEUE_DEPTH];
	entry_t mem_l_q [QUEUE_DEPTH];
	entry_t rd_h_q, rd_l_q, rd_sel;

	logic             op_q, lvl_q;
	logic [7:0]       id_q, burst_q;
	logic [15:0]      thresh_q, slot_q, release_q;
	logic             holder_v_q, lost_q;
	logic [7:0]       holder_id_q;
	logic [PTR_W-1:0] head_h_q, head_l_q, idx_q, best_idx_q;
	logic [CNT_W-1:0] cnt_h_q, cnt_l_q, cnt_sel;
	logic             sel_q;
	logic [15:0]      best_quo_q;
	entry_t           best_e_q, cur_e_q, front_h_q, front_l_q, new_e;

	logic             out_v_q;
	logic [15:0]      out_slot_q;
	logic [7:0]       out_id_q;
	logic             out_busy_q, out_drop_q;

	logic             we_h, we_l;
	logic [PTR_W-1:0] wa_h, wa_l;
	entry_t           wd_h, wd_l;

	logic [15:0]      quo;
	logic             div_busy;
	logic             h_full, l_full, promote_ok, take_cur;

	assign rd_sel  = sel_q ? rd_l_q : rd_h_q;
	assign cnt_sel = sel_q ? cnt_l_q : cnt_h_q;
	assign h_full  = cnt_h_q == DEPTH_C;
	assign l_full  = cnt_l_q == DEPTH_C;
	assign new_e   = '{id: id_q, arrival: slot_q, burst: (burst_q == 8'd0) ? 8'd1 : burst_q};
	assign promote_ok = (cnt_l_q != '0) && !h_full &&
		(16'(slot_q - front_l_q.arrival) >= thresh_q);
	assign take_cur = (idx_q == '0) || (quo > best_quo_q) ||
		((quo == best_quo_q) && (cur_e_q.burst < best_e_q.burst));

	hrrn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (16'(slot_q - rd_sel.arrival)),
		.divisor  (rd_sel.burst),
		.quotient (quo),
		.busy     (div_busy)
	);

	// write port selection, one source per cycle
	always_comb begin
		we_h = 1'b0;
		wa_h = head_h_q;
		wd_h = best_e_q;
		if (cmd.push && lvl_q == LEVEL_HIGH && !h_full) begin
			we_h = 1'b1;
			wa_h = wrap_add(head_h_q, cnt_h_q[PTR_W-1:0]);
			wd_h = new_e;
		end else if (cmd.swap0 && sel_q == LEVEL_HIGH) begin
			we_h = 1'b1;
		end else if (cmd.swap1 && sel_q == LEVEL_HIGH) begin
			we_h = 1'b1;
			wa_h = wrap_add(head_h_q, best_idx_q);
			wd_h = front_h_q;
		end else if (cmd.promote && promote_ok) begin
			we_h = 1'b1;
			wa_h = wrap_add(head_h_q, cnt_h_q[PTR_W-1:0]);
			wd_h = front_l_q;
		end
	end

	always_comb begin
		we_l = 1'b0;
		wa_l = head_l_q;
		wd_l = best_e_q;
		if (cmd.push && lvl_q == LEVEL_LOW && !l_full) begin
			we_l = 1'b1;
			wa_l = wrap_add(head_l_q, cnt_l_q[PTR_W-1:0]);
			wd_l = new_e;
		end else if (cmd.swap0 && sel_q == LEVEL_LOW) begin
			we_l = 1'b1;
		end else if (cmd.swap1 && sel_q == LEVEL_LOW) begin
			we_l = 1'b1;
			wa_l = wrap_add(head_l_q, best_idx_q);
			wd_l = front_l_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_h)
			mem_h_q[wa_h] <= wd_h;
		if (we_l)
			mem_l_q[wa_l] <= wd_l;
		rd_h_q <= mem_h_q[wrap_add(head_h_q, idx_q)];
		rd_l_q <= mem_l_q[wrap_add(head_l_q, idx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= THRESH_RESET;
			slot_q      <= '0;
			holder_v_q  <= 1'b0;
			holder_id_q <= '0;
			release_q   <= '0;
			lost_q      <= 1'b0;
			head_h_q    <= '0;
			head_l_q    <= '0;
			cnt_h_q     <= '0;
			cnt_l_q     <= '0;
			sel_q       <= LEVEL_HIGH;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_valid)
				thresh_q <= cfg_data;
			if (cmd.push) begin
				if (lvl_q == LEVEL_HIGH) begin
					if (h_full)
						lost_q <= 1'b1;
					else
						cnt_h_q <= cnt_h_q + CNT_W'(1);
				end else begin
					if (l_full)
						lost_q <= 1'b1;
					else
						cnt_l_q <= cnt_l_q + CNT_W'(1);
				end
			end
			if (cmd.rel_chk && holder_v_q && slot_q == release_q)
				holder_v_q <= 1'b0;
			if (cmd.scan_init)
				sel_q <= cmd.scan_sel;
			if (cmd.promote && promote_ok) begin
				head_l_q <= wrap_add(head_l_q, PTR_W'(1));
				cnt_l_q  <= cnt_l_q - CNT_W'(1);
				cnt_h_q  <= cnt_h_q + CNT_W'(1);
			end
			if (cmd.dispatch) begin
				if (cnt_h_q != '0) begin
					head_h_q    <= wrap_add(head_h_q, PTR_W'(1));
					cnt_h_q     <= cnt_h_q - CNT_W'(1);
					holder_v_q  <= 1'b1;
					holder_id_q <= front_h_q.id;
					release_q   <= slot_q + 16'(front_h_q.burst);
				end else if (cnt_l_q != '0) begin
					head_l_q    <= wrap_add(head_l_q, PTR_W'(1));
					cnt_l_q     <= cnt_l_q - CNT_W'(1);
					holder_v_q  <= 1'b1;
					holder_id_q <= front_l_q.id;
					release_q   <= slot_q + 16'(front_l_q.burst);
				end
			end
			if (cmd.report) begin
				slot_q  <= slot_q + 16'd1;
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			id_q    <= requester_id;
			lvl_q   <= level;
			burst_q <= slots_wanted;
		end
		if (cmd.scan_init)
			idx_q <= '0;
		if (cmd.div_start)
			cur_e_q <= rd_sel;
		if (cmd.cmp) begin
			if (take_cur) begin
				best_quo_q <= quo;
				best_e_q   <= cur_e_q;
				best_idx_q <= idx_q;
			end
			if (idx_q == '0) begin
				if (sel_q == LEVEL_HIGH)
					front_h_q <= cur_e_q;
				else
					front_l_q <= cur_e_q;
			end
			if (!sts.scan_last)
				idx_q <= idx_q + PTR_W'(1);
		end
		// winner now sits at the front
		if (cmd.swap1) begin
			if (sel_q == LEVEL_HIGH)
				front_h_q <= best_e_q;
			else
				front_l_q <= best_e_q;
		end
		if (cmd.promote && promote_ok && cnt_h_q == '0)
			front_h_q <= front_l_q;
		if (cmd.report) begin
			out_slot_q <= slot_q;
			out_id_q   <= holder_v_q ? holder_id_q : 8'd0;
			out_busy_q <= holder_v_q;
			out_drop_q <= lost_q;
		end
	end

	always_comb begin
		sts.op           = op_q;
		sts.holder_valid = holder_v_q;
		sts.h_empty      = cnt_h_q == '0;
		sts.l_empty      = cnt_l_q == '0;
		sts.sel          = sel_q;
		sts.scan_last    = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_sel;
		sts.div_busy     = div_busy;
		sts.out_free     = !out_v_q || !out_stall;
	end

	assign slot_time  = out_slot_q;
	assign running_id = out_id_q;
	assign busy_res   = out_busy_q;
	assign dropped    = out_drop_q;
	assign out_valid  = out_v_q;

endmodule

// ===== src/hrrn_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences arrivals, scans, swaps, promotion, dispatch and the report.
// Depends on hrrn_pkg.
module hrrn_ctrl import hrrn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DECODE;
			end
			S_DECODE: state_d = (sts.op == OP_ARRIVAL) ? S_ARRIVE : S_REL;
			S_ARRIVE: state_d = S_IDLE;
			S_REL:    state_d = S_CHK;
			S_CHK: begin
				if (sts.holder_valid)
					state_d = S_REPORT;
				else if (!sts.h_empty || !sts.l_empty)
					state_d = S_RD;
				else
					state_d = S_PROMO;
			end
			S_RD:   state_d = S_LOAD;
			S_LOAD: state_d = S_DIVW;
			S_DIVW: begin
				if (!sts.div_busy)
					state_d = S_CMP;
			end
			S_CMP:   state_d = sts.scan_last ? S_SWAP0 : S_RD;
			S_SWAP0: state_d = S_SWAP1;
			S_SWAP1: begin
				if (sts.sel == LEVEL_HIGH && !sts.l_empty)
					state_d = S_RD;
				else
					state_d = S_PROMO;
			end
			S_PROMO: state_d = S_DISP;
			S_DISP:  state_d = S_REPORT;
			S_REPORT: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.latch = in_valid;
			S_ARRIVE: cmd.push = 1'b1;
			S_REL:    cmd.rel_chk = 1'b1;
			S_CHK: begin
				if (!sts.holder_valid && (!sts.h_empty || !sts.l_empty)) begin
					cmd.scan_init = 1'b1;
					cmd.scan_sel  = sts.h_empty ? LEVEL_LOW : LEVEL_HIGH;
				end
			end
			S_LOAD:  cmd.div_start = 1'b1;
			S_DIVW:  cmd.cmp = 1'b0;
			S_CMP:   cmd.cmp = 1'b1;
			S_SWAP0: cmd.swap0 = 1'b1;
			S_SWAP1: begin
				cmd.swap1 = 1'b1;
				if (sts.sel == LEVEL_HIGH && !sts.l_empty) begin
					cmd.scan_init = 1'b1;
					cmd.scan_sel  = LEVEL_LOW;
				end
			end
			S_PROMO:  cmd.promote = 1'b1;
			S_DISP:   cmd.dispatch = 1'b1;
			S_REPORT: cmd.report = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// ===== src/hrrn_two_level_scheduler.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid / in_stall  op, requester_id, level, slots_wanted
// out       out_valid / out_stall slot_time, running_id, busy_res, dropped
// cfg       cfg_valid / cfg_ready cfg_data (promotion threshold)
//
// An arrival is decoded and pushed. A tick checks the release, then reports at once
// while a job holds the slot; else each non-empty queue is scanned (a read, a load
// and the shared 16-step serial divide per entry) and its best entry swapped to the
// front, then promotion, dispatch and the report follow; in_stall holds off requests.
// Reset is asynchronous and active low; queue memories need no clearing.
// A stalled result is held in the output register; the next tick waits for it.
module hrrn_two_level_scheduler import hrrn_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  requester_id,
	input  logic        level,
	input  logic [7:0]  slots_wanted,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] slot_time,
	output logic [7:0]  running_id,
	output logic        busy_res,
	output logic        dropped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	hrrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrrn_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.requester_id (requester_id),
		.level        (level),
		.slots_wanted (slots_wanted),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.slot_time    (slot_time),
		.running_id   (running_id),
		.busy_res     (busy_res),
		.dropped      (dropped),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	a_report_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> sts.out_free)
		else $error("result register overwritten");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.div_busy)
		else $error("divider busy while idle");

	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dispatch && !(sts.h_empty && sts.l_empty) |=> sts.holder_valid)
		else $error("dispatch left slot idle");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.swap0, cmd.swap1, cmd.promote, cmd.dispatch}))
		else $error("conflicting queue updates");

endmodule

// ===== dv/hrrn_two_level_scheduler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-level HRRN slot scheduler.
// Arrival and tick requests come from a queue; results are checked against a scheduler model.
// Depends on hrrn_pkg and hrrn_two_level_scheduler.
module hrrn_two_level_scheduler_tb import hrrn_pkg::*; ();

	localparam int DEPTH = 16;
	localparam int DRAIN_CYCLES = 800;

	typedef struct {
		logic       op;
		logic [7:0] id;
		logic       level;
		logic [7:0] wanted;
	} request_t;

	typedef struct {
		logic [15:0] slot;
		logic [7:0]  id;
		logic        busy;
		logic        lost;
	} slot_report_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  requester_id;
	logic        level;
	logic [7:0]  slots_wanted;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] slot_time;
	logic [7:0]  running_id;
	logic        busy_res;
	logic        dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	hrrn_two_level_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .requester_id(requester_id), .level(level), .slots_wanted(slots_wanted),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_time(slot_time), .running_id(running_id), .busy_res(busy_res),
		.dropped(dropped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// scheduler model state
	entry_t      high_q[$];
	entry_t      low_q[$];
	logic [15:0] now_slot;
	logic [15:0] threshold;
	logic        holding;
	logic [7:0]  holder;
	logic [15:0] release_slot;
	logic        lost_sticky;

	request_t     pending_requests[$];
	slot_report_t expected_reports[$];
	int           mismatches;
	bit           hold_request;
	bit           sender_quiet;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("ERROR at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int unsigned response_ratio(entry_t e);
		logic [15:0] waited;
		int unsigned b;
		waited = now_slot - e.arrival;
		b = (e.burst == 0) ? 1 : e.burst;
		return (int'(waited) + b) / b;
	endfunction

	// swap the best response ratio to the front; ties to shorter burst, then earlier queue position
	task automatic bring_best_forward(ref entry_t q[$]);
		int best;
		int unsigned best_r;
		int unsigned r;
		entry_t t;
		if (q.size() == 0)
			return;
		best = 0;
		best_r = response_ratio(q[0]);
		for (int i = 1; i < q.size(); i++) begin
			r = response_ratio(q[i]);
			if (r > best_r || (r == best_r && q[i].burst < q[best].burst)) begin
				best = i;
				best_r = r;
			end
		end
		t = q[0];
		q[0] = q[best];
		q[best] = t;
	endtask

	task automatic schedule_request(input request_t rq);
		entry_t e;
		entry_t f;
		slot_report_t rep;
		if (rq.op == OP_ARRIVAL) begin
			e.id = rq.id;
			e.arrival = now_slot;
			e.burst = (rq.wanted == 0) ? 8'd1 : rq.wanted;
			if (rq.level == LEVEL_LOW) begin
				if (low_q.size() < DEPTH) low_q.insert(low_q.size(), e);
				else lost_sticky = 1'b1;
			end else begin
				if (high_q.size() < DEPTH) high_q.insert(high_q.size(), e);
				else lost_sticky = 1'b1;
			end
			return;
		end
		if (holding && now_slot == release_slot)
			holding = 1'b0;
		if (!holding) begin
			bring_best_forward(high_q);
			bring_best_forward(low_q);
			if (low_q.size() > 0 && high_q.size() < DEPTH &&
			    logic'(16'(now_slot - low_q[0].arrival) >= threshold)) begin
				f = low_q[0];
				low_q.delete(0);
				high_q.insert(high_q.size(), f);
			end
			if (high_q.size() > 0 || low_q.size() > 0) begin
				if (high_q.size() > 0) begin
					f = high_q[0];
					high_q.delete(0);
				end else begin
					f = low_q[0];
					low_q.delete(0);
				end
				holding = 1'b1;
				holder = f.id;
				release_slot = now_slot + 16'(f.burst);
			end
		end
		rep.slot = now_slot;
		rep.id = holding ? holder : 8'd0;
		rep.busy = holding;
		rep.lost = lost_sticky;
		expected_reports.insert(expected_reports.size(), rep);
		now_slot = now_slot + 16'd1;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// driver
	request_t on_wire;
	int       send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_TICK;
			requester_id <= '0;
			level <= LEVEL_HIGH;
			slots_wanted <= 8'd1;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				schedule_request(on_wire);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					on_wire = pending_requests[0];
					pending_requests.delete(0);
					op <= on_wire.op;
					requester_id <= on_wire.id;
					level <= on_wire.level;
					slots_wanted <= on_wire.wanted;
					in_valid <= 1'b1;
					send_gap <= sender_quiet ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and stall generator
	int stall_left;
	int hold_left;
	slot_report_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("unexpected report for slot %0d", slot_time));
				end else begin
					want = expected_reports[0];
					expected_reports.delete(0);
					if (slot_time !== want.slot)
						report_mismatch($sformatf("slot_time %0d, want %0d",
							slot_time, want.slot));
					if (running_id !== want.id)
						report_mismatch($sformatf("slot %0d running_id %0d, want %0d",
							want.slot, running_id, want.id));
					if (busy_res !== want.busy)
						report_mismatch($sformatf("slot %0d busy_res %0b, want %0b",
							want.slot, busy_res, want.busy));
					if (dropped !== want.lost)
						report_mismatch($sformatf("slot %0d dropped %0b, want %0b",
							want.slot, dropped, want.lost));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left <= 3000;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!sender_quiet && $urandom_range(3) == 0) begin
				stall_left <= pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic request_t random_request();
		request_t rq;
		int r;
		rq.op = ($urandom_range(99) < 45) ? OP_TICK : OP_ARRIVAL;
		rq.id = 8'($urandom_range(255));
		rq.level = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 70) rq.wanted = 8'($urandom_range(6, 1));
		else if (r < 95) rq.wanted = 8'($urandom_range(40, 7));
		else rq.wanted = 8'($urandom_range(255));
		return rq;
	endfunction

	function automatic request_t make_request(logic o, logic [7:0] i, logic l, logic [7:0] w);
		request_t rq;
		rq.op = o;
		rq.id = i;
		rq.level = l;
		rq.wanted = w;
		return rq;
	endfunction

	// hold the sender until every expected report is in and the block has settled
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_requests.size() > 0 || in_valid || expected_reports.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		threshold = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++)
			pending_requests.insert(pending_requests.size(), random_request());
	endtask

	initial begin
		high_q = {};
		low_q = {};
		now_slot = '0;
		threshold = THRESH_RESET;
		holding = 1'b0;
		holder = '0;
		release_slot = '0;
		lost_sticky = 1'b0;
		mismatches = 0;
		hold_request = 1'b0;
		sender_quiet = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: id and burst extremes, zero burst, both levels, overfull high queue
		pending_requests.insert(pending_requests.size(),
			make_request(OP_TICK, 8'd0, LEVEL_HIGH, 8'd1));
		pending_requests.insert(pending_requests.size(),
			make_request(OP_ARRIVAL, 8'd255, LEVEL_LOW, 8'd255));
		pending_requests.insert(pending_requests.size(),
			make_request(OP_ARRIVAL, 8'd0, LEVEL_LOW, 8'd0));
		for (int i = 0; i < 17; i++)
			pending_requests.insert(pending_requests.size(),
				make_request(OP_ARRIVAL, 8'(i * 15), LEVEL_HIGH,
				(i == 3) ? 8'd0 : (i == 5) ? 8'd255 : 8'(i % 4 + 1)));
		repeat (4)
			pending_requests.insert(pending_requests.size(),
				make_request(OP_TICK, 8'hA5, LEVEL_LOW, 8'hFF));
		wait_quiet();

		random_phase(220);
		wait_quiet();

		// promote at once, with a long receiver hold to back up the input
		write_threshold(16'd0);
		hold_request = 1'b1;
		random_phase(220);
		wait_quiet();

		write_threshold(16'hFFFF);
		random_phase(200);
		wait_quiet();

		write_threshold(16'($urandom_range(30, 2)));
		random_phase(200);
		wait_quiet();

		write_threshold(THRESH_RESET);
		random_phase(150);
		wait_quiet();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
